>>> design/assert_macros.svh
// Assertion macros included by the fork history cache design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising clk edge, outside reset.
`define BFHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds on a rising clk edge, outside reset.
`define BFHC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BFHC_ASSERT(lbl, prop, msg)
`define BFHC_NEVER(lbl, cond, msg)
`endif

`endif

>>> design/bfhc_pkg.sv
// Shared widths, opcodes, status codes and register indexes of the fork history cache.
package bfhc_pkg;

  localparam int OP_W       = 1;
  localparam int IN_KEY_W   = 64;
  localparam int STATUS_W   = 3;
  localparam int FTOT_W     = 4;
  localparam int RTOT_W     = 11;
  localparam int MAXR_W     = 11;
  localparam int MAXF_W     = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [OP_W-1:0] {
    OP_PUT = 1'b0,
    OP_GET = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW_ROOT  = 3'd0,
    ST_FORK_ADD  = 3'd1,
    ST_FORK_DUP  = 3'd2,
    ST_GET_HIT   = 3'd3,
    ST_GET_MISS  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_ROOTS = 1'b0,
    REG_MAX_FORKS = 1'b1
  } reg_idx_t;

endpackage

>>> design/bfhc_if.sv
// Request and result channel interfaces of the fork history cache.
interface bfhc_in_if
  import bfhc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [IN_KEY_W-1:0] root_key;
  logic [IN_KEY_W-1:0] fork_hash;

  modport source (output valid, output opcode, output root_key, output fork_hash,
                  input ready);
  modport sink   (input valid, input opcode, input root_key, input fork_hash,
                  output ready);
endinterface

interface bfhc_out_if
  import bfhc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                fork_dropped;
  logic                root_evicted;
  logic [IN_KEY_W-1:0] hash_out;
  logic [FTOT_W-1:0]   fork_total;
  logic [RTOT_W-1:0]   root_total;
  logic                last;

  modport source (output valid, output status, output fork_dropped, output root_evicted,
                  output hash_out, output fork_total, output root_total, output last,
                  input ready);
  modport sink   (input valid, input status, input fork_dropped, input root_evicted,
                  input hash_out, input fork_total, input root_total, input last,
                  output ready);
endinterface

>>> design/bounded_fork_history_cache.sv
// Bounded fork history cache: root ring, per-root fork lists, scan and update sequencer.
// Sequence: a put scans roots (up to root count), then compares forks (up to the root's
//   fork count) before its update; a get miss only scans the roots.
// Throughput: one word at a time; a get hit streams its hash words in turn, each read
//   through the single registered read port of the fork memory. The key scan, one slot
//   a cycle on the key memory read port, sets the pace for large root counts.
// Reset: synchronous, active low; clears the ring pointers, count, sequencer and output
//   valid, and loads max_roots = 1024, max_forks = 8. Memories are not cleared.
module bounded_fork_history_cache
  import bfhc_pkg::*;
#(
  parameter int ROOT_SLOTS = 1024,
  parameter int FORK_SLOTS = 8,
  parameter int KEY_BITS   = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bfhc_in_if.sink               in_ch,
  bfhc_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  `include "assert_macros.svh"

  localparam int SW   = $clog2(ROOT_SLOTS);
  localparam int CW   = $clog2(ROOT_SLOTS + 1);
  localparam int FCW  = $clog2(FORK_SLOTS + 1);
  localparam int FHW  = (FORK_SLOTS > 1) ? $clog2(FORK_SLOTS) : 1;
  localparam int AW   = (ROOT_SLOTS * FORK_SLOTS > 1) ? $clog2(ROOT_SLOTS * FORK_SLOTS) : 1;
  localparam int SUMW = FCW + 1;

  typedef struct packed {
    logic [FCW-1:0] cnt;
    logic [FHW-1:0] head;
  } meta_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DUP, S_GRD, S_GOUT, S_NEW, S_UPD, S_EMIT
  } state_t;

  // Storage: keys and per-root list state by ring slot, fork hashes by slot and list slot.
  logic [KEY_BITS-1:0] key_mem  [ROOT_SLOTS];
  meta_t               meta_mem [ROOT_SLOTS];
  logic [KEY_BITS-1:0] fork_mem [ROOT_SLOTS * FORK_SLOTS];

  logic [KEY_BITS-1:0] key_rd_r;
  meta_t               meta_rd_r;
  logic [KEY_BITS-1:0] fork_rd_r;

  state_t              state_r;
  logic [MAXR_W-1:0]   max_roots_r;
  logic [MAXF_W-1:0]   max_forks_r;
  logic [SW-1:0]       root_head_r, root_tail_r;
  logic [CW-1:0]       root_count_r;

  logic [OP_W-1:0]     op_r;
  logic [KEY_BITS-1:0] key_r, hash_r;
  logic [SW-1:0]       scan_slot_r, slot_r;
  logic [CW-1:0]       scan_n_r;
  logic [FCW-1:0]      cnt_r, idx_r;
  logic [FHW-1:0]      ptr_r, list_head_r;
  logic [STATUS_W-1:0] pend_status_r;
  logic [FTOT_W-1:0]   pend_ftot_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_dropped_r, out_evicted_r, out_last_r;
  logic [IN_KEY_W-1:0] out_hash_r;
  logic [FTOT_W-1:0]   out_ftot_r;
  logic [RTOT_W-1:0]   out_rtot_r;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == SW'(ROOT_SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [FHW-1:0] ptr_inc(input logic [FHW-1:0] p);
    return (p == FHW'(FORK_SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] faddr(input logic [SW-1:0] s, input logic [FHW-1:0] p);
    return AW'(s) * AW'(FORK_SLOTS) + AW'(p);
  endfunction

  // Clamped limits.
  logic [CW-1:0]  rcap;
  logic [FCW-1:0] fcap;
  always_comb begin
    if (max_roots_r == '0) begin
      rcap = CW'(1);
    end else if (32'(max_roots_r) > ROOT_SLOTS) begin
      rcap = CW'(ROOT_SLOTS);
    end else begin
      rcap = CW'(max_roots_r);
    end
    if (max_forks_r == '0) begin
      fcap = FCW'(1);
    end else if (32'(max_forks_r) > FORK_SLOTS) begin
      fcap = FCW'(FORK_SLOTS);
    end else begin
      fcap = FCW'(max_forks_r);
    end
  end

  logic in_fire, out_free, out_load;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  // States that load a result word into the output register.
  assign out_load = out_free && (state_r inside {S_GOUT, S_NEW, S_UPD, S_EMIT});

  // Scan and compare decisions on the key and fork words read in the previous cycle.
  logic scan_hit, scan_end, dup_hit, dup_end, gout_last;
  assign scan_hit  = (key_rd_r == key_r);
  assign scan_end  = ((scan_n_r + 1'b1) == root_count_r);
  assign dup_hit   = (fork_rd_r == hash_r);
  assign dup_end   = ((idx_r + 1'b1) == cnt_r);
  assign gout_last = ((idx_r + 1'b1) == cnt_r);

  // Put: append position, drop and eviction on a known root, eviction on a new root.
  logic [SUMW-1:0] pos_sum;
  logic [FHW-1:0]  upd_pos;
  logic            upd_drop, upd_evict, new_evict;
  meta_t           upd_meta;
  logic [FCW-1:0]  upd_ftot;
  always_comb begin
    pos_sum   = SUMW'(ptr_r) + SUMW'(cnt_r);
    upd_pos   = (pos_sum >= SUMW'(FORK_SLOTS)) ? FHW'(pos_sum - SUMW'(FORK_SLOTS))
                                               : FHW'(pos_sum);
    upd_drop  = (cnt_r >= fcap);
    upd_evict = (root_count_r > rcap);
    new_evict = (root_count_r >= rcap);
    if (upd_drop) begin
      upd_meta.cnt  = cnt_r;
      upd_meta.head = ptr_inc(ptr_r);
    end else begin
      upd_meta.cnt  = cnt_r + 1'b1;
      upd_meta.head = ptr_r;
    end
    // The evicted root may be the one just updated.
    upd_ftot = (upd_evict && (slot_r == root_head_r)) ? '0 : upd_meta.cnt;
  end

  // Memory ports: keys and list state read each cycle, at the next scan slot or ring head.
  logic [SW-1:0]       rd_slot;
  logic                fork_re;
  logic [AW-1:0]       fork_raddr;
  logic                key_we, meta_we, fork_we;
  logic [SW-1:0]       wr_slot;
  meta_t               wr_meta;
  logic [AW-1:0]       fork_waddr;

  always_comb begin
    rd_slot    = (state_r == S_SCAN) ? slot_inc(scan_slot_r) : root_head_r;
    fork_re    = 1'b0;
    fork_raddr = faddr(slot_r, ptr_r);
    case (state_r)
      S_SCAN: begin
        if (scan_hit && op_r == OP_PUT && meta_rd_r.cnt != '0) begin
          fork_re    = 1'b1;
          fork_raddr = faddr(scan_slot_r, meta_rd_r.head);
        end
      end
      S_DUP: begin
        if (!dup_hit && !dup_end) begin
          fork_re    = 1'b1;
          fork_raddr = faddr(slot_r, ptr_inc(ptr_r));
        end
      end
      S_GRD: begin
        fork_re = 1'b1;
      end
      default: begin
      end
    endcase

    key_we     = (state_r == S_NEW) && out_free;
    meta_we    = ((state_r == S_NEW) || (state_r == S_UPD)) && out_free;
    fork_we    = meta_we;
    wr_slot    = (state_r == S_NEW) ? root_tail_r : slot_r;
    fork_waddr = (state_r == S_NEW) ? faddr(root_tail_r, '0) : faddr(slot_r, upd_pos);
    if (state_r == S_NEW) begin
      wr_meta.cnt  = FCW'(1);
      wr_meta.head = '0;
    end else begin
      wr_meta = upd_meta;
    end
  end

  // Accesses never overlap: each word finishes its writes before the next word's reads.
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_slot] <= key_r;
    end
    key_rd_r <= key_mem[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[wr_slot] <= wr_meta;
    end
    meta_rd_r <= meta_mem[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (fork_we) begin
      fork_mem[fork_waddr] <= hash_r;
    end
    if (fork_re) begin
      fork_rd_r <= fork_mem[fork_raddr];
    end
  end

  // Sequencer, ring pointers, configuration and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      max_roots_r  <= MAXR_W'(1024);
      max_forks_r  <= MAXF_W'(8);
      root_head_r  <= '0;
      root_tail_r  <= '0;
      root_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_MAX_ROOTS: max_roots_r <= cfg_data[MAXR_W-1:0];
          REG_MAX_FORKS: max_forks_r <= cfg_data[MAXF_W-1:0];
          default: begin
          end
        endcase
      end

      // Raise valid on a load; drop the held result word once taken.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            op_r        <= in_ch.opcode;
            key_r       <= in_ch.root_key[KEY_BITS-1:0];
            hash_r      <= in_ch.fork_hash[KEY_BITS-1:0];
            scan_slot_r <= rd_slot;
            scan_n_r    <= '0;
            if (root_count_r != '0) begin
              state_r <= S_SCAN;
            end else if (in_ch.opcode == OP_GET) begin
              pend_status_r <= ST_GET_MISS;
              pend_ftot_r   <= '0;
              state_r       <= S_EMIT;
            end else begin
              state_r <= S_NEW;
            end
          end
        end

        S_SCAN: begin
          if (scan_hit) begin
            slot_r      <= scan_slot_r;
            cnt_r       <= meta_rd_r.cnt;
            ptr_r       <= meta_rd_r.head;
            list_head_r <= meta_rd_r.head;
            idx_r       <= '0;
            if (meta_rd_r.cnt == '0) begin
              if (op_r == OP_GET) begin
                pend_status_r <= ST_GET_HIT;
                pend_ftot_r   <= '0;
                state_r       <= S_EMIT;
              end else begin
                state_r <= S_UPD;
              end
            end else begin
              state_r <= (op_r == OP_GET) ? S_GRD : S_DUP;
            end
          end else if (scan_end) begin
            if (op_r == OP_GET) begin
              pend_status_r <= ST_GET_MISS;
              pend_ftot_r   <= '0;
              state_r       <= S_EMIT;
            end else begin
              state_r <= S_NEW;
            end
          end else begin
            scan_slot_r <= rd_slot;
            scan_n_r    <= scan_n_r + 1'b1;
          end
        end

        S_DUP: begin
          if (dup_hit) begin
            pend_status_r <= ST_FORK_DUP;
            pend_ftot_r   <= FTOT_W'(cnt_r);
            state_r       <= S_EMIT;
          end else if (dup_end) begin
            // Restore the list head for the append position.
            ptr_r   <= list_head_r;
            state_r <= S_UPD;
          end else begin
            ptr_r <= ptr_inc(ptr_r);
            idx_r <= idx_r + 1'b1;
          end
        end

        S_GRD: begin
          state_r <= S_GOUT;
        end

        S_GOUT: begin
          if (out_free) begin
            out_status_r  <= ST_GET_HIT;
            out_dropped_r <= 1'b0;
            out_evicted_r <= 1'b0;
            out_hash_r    <= IN_KEY_W'(fork_rd_r);
            out_ftot_r    <= FTOT_W'(cnt_r);
            out_rtot_r    <= RTOT_W'(root_count_r);
            out_last_r    <= gout_last;
            if (gout_last) begin
              state_r <= S_IDLE;
            end else begin
              ptr_r   <= ptr_inc(ptr_r);
              idx_r   <= idx_r + 1'b1;
              state_r <= S_GRD;
            end
          end
        end

        S_NEW: begin
          if (out_free) begin
            root_tail_r  <= slot_inc(root_tail_r);
            root_head_r  <= new_evict ? slot_inc(root_head_r) : root_head_r;
            root_count_r <= new_evict ? root_count_r : root_count_r + 1'b1;
            out_status_r  <= ST_NEW_ROOT;
            out_dropped_r <= 1'b0;
            out_evicted_r <= new_evict;
            out_hash_r    <= '0;
            out_ftot_r    <= FTOT_W'(1);
            out_rtot_r    <= RTOT_W'(new_evict ? root_count_r : root_count_r + 1'b1);
            out_last_r    <= 1'b1;
            state_r       <= S_IDLE;
          end
        end

        S_UPD: begin
          if (out_free) begin
            if (upd_evict) begin
              root_head_r  <= slot_inc(root_head_r);
              root_count_r <= root_count_r - 1'b1;
            end
            out_status_r  <= ST_FORK_ADD;
            out_dropped_r <= upd_drop;
            out_evicted_r <= upd_evict;
            out_hash_r    <= '0;
            out_ftot_r    <= FTOT_W'(upd_ftot);
            out_rtot_r    <= RTOT_W'(upd_evict ? root_count_r - 1'b1 : root_count_r);
            out_last_r    <= 1'b1;
            state_r       <= S_IDLE;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            out_status_r  <= pend_status_r;
            out_dropped_r <= 1'b0;
            out_evicted_r <= 1'b0;
            out_hash_r    <= '0;
            out_ftot_r    <= pend_ftot_r;
            out_rtot_r    <= RTOT_W'(root_count_r);
            out_last_r    <= 1'b1;
            state_r       <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.fork_dropped = out_dropped_r;
  assign out_ch.root_evicted = out_evicted_r;
  assign out_ch.hash_out     = out_hash_r;
  assign out_ch.fork_total   = out_ftot_r;
  assign out_ch.root_total   = out_rtot_r;
  assign out_ch.last         = out_last_r;

  // Ring bookkeeping: tail always sits count slots past head.
  logic [CW:0] ring_sum;
  logic [SW-1:0] ring_tail;
  always_comb begin
    ring_sum  = (CW + 1)'(root_head_r) + (CW + 1)'(root_count_r);
    ring_tail = (ring_sum >= (CW + 1)'(ROOT_SLOTS)) ? SW'(ring_sum - (CW + 1)'(ROOT_SLOTS))
                                                    : SW'(ring_sum);
  end

  `BFHC_ASSERT(a_ring_tail, ring_tail == root_tail_r, "root ring tail out of step")
  `BFHC_NEVER(a_count_bound, root_count_r > CW'(ROOT_SLOTS), "root count above slots")
  `BFHC_ASSERT(a_dup_idx, (state_r != S_DUP) || (idx_r < cnt_r), "fork compare overran")
  `BFHC_NEVER(a_hit_cnt,
              (state_r == S_SCAN) && scan_hit && (meta_rd_r.cnt > FCW'(FORK_SLOTS)),
              "stored fork count too large")

endmodule
